>>> rtl/spu_pkg.sv
// shared widths, codes and types for the potts site update block
package spu_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SITE_W     = 12;
  localparam int SPIN_W     = 3;
  localparam int THR_W      = 18;
  localparam int FIELD_W    = 16;
  localparam int BOND_OUT_W = 15;
  localparam int MAG_OUT_W  = 14;
  localparam int TOTAL_W    = 30;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_Z = 2'd2;

  // spin codes, bit 0 is the sign, bits 2:1 the axis
  localparam logic [SPIN_W-1:0] SPIN_PX = 3'd0;
  localparam logic [SPIN_W-1:0] SPIN_NX = 3'd1;
  localparam logic [SPIN_W-1:0] SPIN_PY = 3'd2;
  localparam logic [SPIN_W-1:0] SPIN_NY = 3'd3;
  localparam logic [SPIN_W-1:0] SPIN_PZ = 3'd4;
  localparam logic [SPIN_W-1:0] SPIN_NZ = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } field_t;

  function automatic int addr_w(input int side);
    return $clog2(side * side * side);
  endfunction

  // queue entry: ok flag, spin, threshold, site and six neighbour addresses
  function automatic int entry_w(input int side);
    return 1 + SPIN_W + THR_W + 7 * addr_w(side);
  endfunction

endpackage

>>> rtl/metropolis_potts_site_update_core.sv
// Metropolis update of a six-state Potts lattice held in one on-chip memory of SIDE^3 spins.
// After reset a clearing pass writes +x to every site, during which in_stall stays high;
// field registers can be written at any time. The back end handles each move as a pop,
// seven reads of the lattice read port (own spin and six neighbours) with registered read
// data, the decision and write-back, then the three field terms through the shared
// field-by-magnetisation multiplier for the total energy. A request whose site or spin
// code is out of range skips the reads. The front end splits the site into coordinates
// and runs ahead through a two-deep queue; the result register lets the next move start
// while a result waits.
module metropolis_potts_site_update_core #(
  parameter int SIDE = spu_pkg::SIDE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [spu_pkg::SITE_W-1:0]            site,
  input  logic [spu_pkg::SPIN_W-1:0]            proposed_spin,
  input  logic [spu_pkg::THR_W-1:0]             threshold,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  accepted,
  output logic signed [spu_pkg::BOND_OUT_W-1:0] bond_energy,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_x_out,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_y_out,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_z_out,
  output logic signed [spu_pkg::TOTAL_W-1:0]    total_energy,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [spu_pkg::FIELD_W-1:0]           cfg_data
);

  localparam int EW = spu_pkg::entry_w(SIDE);

  spu_pkg::field_t fields;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [EW-1:0]   q_din;
  logic [EW-1:0]   q_dout;
  logic            clr_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spu_pkg::REG_FIELD_X: fields.x <= $signed(cfg_data);
        spu_pkg::REG_FIELD_Y: fields.y <= $signed(cfg_data);
        spu_pkg::REG_FIELD_Z: fields.z <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  spu_front #(
    .SIDE (SIDE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .site          (site),
    .proposed_spin (proposed_spin),
    .threshold     (threshold),
    .clr_busy      (clr_busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_din)
  );

  spu_fifo #(
    .W (EW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  spu_back #(
    .SIDE (SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .fields       (fields),
    .q_entry      (q_dout),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .clr_busy     (clr_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .bond_energy  (bond_energy),
    .mag_x_out    (mag_x_out),
    .mag_y_out    (mag_y_out),
    .mag_z_out    (mag_z_out),
    .total_energy (total_energy)
  );

endmodule

>>> rtl/spu_front.sv
// front end: takes a request, splits the site into coordinates, forms neighbour addresses
module spu_front #(
  parameter int SIDE = spu_pkg::SIDE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [spu_pkg::SITE_W-1:0]           site,
  input  logic [spu_pkg::SPIN_W-1:0]           proposed_spin,
  input  logic [spu_pkg::THR_W-1:0]            threshold,
  input  logic                                 clr_busy,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [spu_pkg::entry_w(SIDE)-1:0]    q_entry
);

  localparam int NSITES = SIDE * SIDE * SIDE;
  localparam int SS     = SIDE * SIDE;
  localparam int AW     = spu_pkg::addr_w(SIDE);
  localparam int CW     = $clog2(SIDE);
  localparam int RW     = $clog2(SS);
  localparam int SEW    = (AW > spu_pkg::SITE_W) ? AW : spu_pkg::SITE_W;
  localparam logic [16:0] RX_MUL = 17'((1 << 16) / SS);
  localparam logic [16:0] RY_MUL = 17'((1 << 16) / SIDE);
  localparam logic [AW-1:0] STEP_X = AW'(SS);
  localparam logic [AW-1:0] WRAP_X = AW'((SIDE - 1) * SS);
  localparam logic [AW-1:0] STEP_Y = AW'(SIDE);
  localparam logic [AW-1:0] WRAP_Y = AW'((SIDE - 1) * SIDE);
  localparam logic [AW-1:0] STEP_Z = AW'(1);
  localparam logic [AW-1:0] WRAP_Z = AW'(SIDE - 1);
  localparam logic [CW-1:0] CMAX   = CW'(SIDE - 1);

  typedef enum logic [2:0] {F_IDLE, F_QX, F_RX, F_QY, F_RY, F_PUSH} state_t;

  state_t                       st;
  logic [spu_pkg::SITE_W-1:0]   site_r;
  logic [spu_pkg::SPIN_W-1:0]   prop_r;
  logic [spu_pkg::THR_W-1:0]    thr_r;
  logic                         ok_r;
  logic [11:0]                  q_r;
  logic [RW-1:0]                rem_r;
  logic [CW-1:0]                x_r;
  logic [CW-1:0]                y_r;
  logic [CW-1:0]                z_r;

  logic [28:0]    prod_x;
  logic [23:0]    px;
  logic [12:0]    rem_w;
  logic [RW+16:0] prod_y;
  logic [23:0]    py;
  logic [RW:0]    rem_z;
  logic [SEW-1:0] site_ext;
  logic [AW-1:0]  site_a;
  logic [AW-1:0]  nb [6];
  logic           take;

  assign in_stall = (st != F_IDLE) || clr_busy;
  assign take     = in_valid && !in_stall;

  // quotient estimates by reciprocal, at most one short, fixed by a compare and subtract
  assign prod_x = 29'(site_r) * 29'(RX_MUL);
  assign px     = 24'(q_r) * 24'(SS);
  assign rem_w  = 13'(site_r) - px[12:0];
  assign prod_y = (RW + 17)'(rem_r) * (RW + 17)'(RY_MUL);
  assign py     = 24'(q_r) * 24'(SIDE);
  assign rem_z  = (RW + 1)'(rem_r) - py[RW:0];

  assign site_ext = SEW'(site_r);
  assign site_a   = site_ext[AW-1:0];

  // periodic neighbours straight from the site address
  always_comb begin
    nb[0] = (x_r == CMAX) ? site_a - WRAP_X : site_a + STEP_X;
    nb[1] = (x_r == '0)   ? site_a + WRAP_X : site_a - STEP_X;
    nb[2] = (y_r == CMAX) ? site_a - WRAP_Y : site_a + STEP_Y;
    nb[3] = (y_r == '0)   ? site_a + WRAP_Y : site_a - STEP_Y;
    nb[4] = (z_r == CMAX) ? site_a - WRAP_Z : site_a + STEP_Z;
    nb[5] = (z_r == '0)   ? site_a + WRAP_Z : site_a - STEP_Z;
  end

  assign q_push  = (st == F_PUSH) && !q_full;
  assign q_entry = {ok_r, prop_r, thr_r, site_a, nb[0], nb[1], nb[2], nb[3], nb[4], nb[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (take) begin
            site_r <= site;
            prop_r <= proposed_spin;
            thr_r  <= threshold;
            ok_r   <= (proposed_spin <= spu_pkg::SPIN_NZ) && (32'(site) < 32'(NSITES));
            st     <= F_QX;
          end
        end
        F_QX: begin
          q_r <= prod_x[27:16];
          st  <= F_RX;
        end
        F_RX: begin
          if (rem_w >= 13'(SS)) begin
            x_r   <= CW'(q_r + 12'd1);
            rem_r <= RW'(rem_w - 13'(SS));
          end else begin
            x_r   <= CW'(q_r);
            rem_r <= RW'(rem_w);
          end
          st <= F_QY;
        end
        F_QY: begin
          q_r <= 12'(prod_y >> 16);
          st  <= F_RY;
        end
        F_RY: begin
          if (rem_z >= (RW + 1)'(SIDE)) begin
            y_r <= CW'(q_r + 12'd1);
            z_r <= CW'(rem_z - (RW + 1)'(SIDE));
          end else begin
            y_r <= CW'(q_r);
            z_r <= CW'(rem_z);
          end
          st <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            st <= F_IDLE;
          end
        end
        default: begin
          st <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/spu_fifo.sv
// short request queue between the front and back ends
module spu_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int DEPTH = spu_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/spu_back.sv
// back end: lattice memory, metropolis test, running totals and result register
module spu_back #(
  parameter int SIDE = spu_pkg::SIDE_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  spu_pkg::field_t                            fields,
  input  logic [spu_pkg::entry_w(SIDE)-1:0]          q_entry,
  input  logic                                       q_empty,
  output logic                                       q_pop,
  output logic                                       clr_busy,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic                                       accepted,
  output logic signed [spu_pkg::BOND_OUT_W-1:0]      bond_energy,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]       mag_x_out,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]       mag_y_out,
  output logic signed [spu_pkg::MAG_OUT_W-1:0]       mag_z_out,
  output logic signed [spu_pkg::TOTAL_W-1:0]         total_energy
);

  localparam int NSITES = SIDE * SIDE * SIDE;
  localparam int AW     = spu_pkg::addr_w(SIDE);
  localparam int EW     = spu_pkg::entry_w(SIDE);
  localparam int BW     = $clog2(3 * NSITES + 1) + 1;
  localparam int MW     = $clog2(NSITES + 1) + 1;
  localparam int SW     = spu_pkg::SPIN_W;
  localparam int TW     = spu_pkg::TOTAL_W;
  localparam int PRW    = spu_pkg::FIELD_W + MW;
  localparam logic [AW-1:0]        LAST_SITE  = AW'(NSITES - 1);
  localparam logic signed [BW-1:0] BOND_RESET = BW'(-3 * NSITES);
  localparam logic signed [MW-1:0] MAG_RESET  = MW'(NSITES);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_DECIDE, B_MULT, B_EMIT} state_t;

  function automatic logic signed [1:0] bond_term(input logic [SW-1:0] a,
                                                  input logic [SW-1:0] b);
    logic signed [1:0] r;
    if (a == b) begin
      r = -2'sd1;
    end else if (a[2:1] == b[2:1]) begin
      r = 2'sd1;
    end else begin
      r = 2'sd0;
    end
    return r;
  endfunction

  function automatic logic signed [19:0] field_dot(input logic [SW-1:0] s,
                                                   input spu_pkg::field_t f);
    logic signed [19:0] v;
    case (s[2:1])
      spu_pkg::AXIS_X: v = 20'(f.x);
      spu_pkg::AXIS_Y: v = 20'(f.y);
      default:         v = 20'(f.z);
    endcase
    return s[0] ? -v : v;
  endfunction

  function automatic logic signed [2:0] unit_comp(input logic [SW-1:0] s,
                                                  input logic [1:0] axis);
    logic signed [2:0] r;
    if (s[2:1] == axis) begin
      r = s[0] ? -3'sd1 : 3'sd1;
    end else begin
      r = 3'sd0;
    end
    return r;
  endfunction

  state_t                   st;
  logic [2:0]               cnt;
  logic [AW-1:0]            clr_addr;
  logic [EW-1:0]            ent_r;
  logic [SW-1:0]            old_r;
  logic signed [3:0]        b_old;
  logic signed [3:0]        b_new;
  logic                     rd_valid;
  logic [2:0]               rd_idx;
  logic                     acc_flag;
  logic signed [BW-1:0]     bond;
  logic signed [MW-1:0]     mag_x;
  logic signed [MW-1:0]     mag_y;
  logic signed [MW-1:0]     mag_z;
  logic signed [TW-1:0]     prod_r;
  logic signed [TW-1:0]     tot;

  logic [SW-1:0] lattice [NSITES];
  logic [SW-1:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [SW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;

  logic                    e_ok;
  logic [SW-1:0]           e_prop;
  logic [spu_pkg::THR_W-1:0] e_thr;
  logic [AW-1:0]           e_site;
  logic signed [4:0]       db;
  logic signed [19:0]      de;
  logic                    move_ok;
  logic signed [2:0]       dm_x;
  logic signed [2:0]       dm_y;
  logic signed [2:0]       dm_z;
  logic signed [spu_pkg::FIELD_W-1:0] f_sel;
  logic signed [MW-1:0]    m_sel;
  logic signed [PRW-1:0]   mul_full;
  logic                    load_out;

  assign e_ok   = ent_r[EW-1];
  assign e_prop = ent_r[EW-2 -: SW];
  assign e_thr  = ent_r[EW-2-SW -: spu_pkg::THR_W];
  assign e_site = ent_r[7*AW-1 -: AW];

  // read order: own site first, then the six neighbours
  always_comb begin
    case (cnt)
      3'd1:    mem_ra = ent_r[6*AW-1 -: AW];
      3'd2:    mem_ra = ent_r[5*AW-1 -: AW];
      3'd3:    mem_ra = ent_r[4*AW-1 -: AW];
      3'd4:    mem_ra = ent_r[3*AW-1 -: AW];
      3'd5:    mem_ra = ent_r[2*AW-1 -: AW];
      3'd6:    mem_ra = ent_r[AW-1 -: AW];
      default: mem_ra = e_site;
    endcase
  end

  assign db      = 5'(b_new) - 5'(b_old);
  assign de      = (20'(db) <<< 8) - field_dot(e_prop, fields) + field_dot(old_r, fields);
  assign move_ok = de < $signed(20'(e_thr));
  assign dm_x    = unit_comp(e_prop, spu_pkg::AXIS_X) - unit_comp(old_r, spu_pkg::AXIS_X);
  assign dm_y    = unit_comp(e_prop, spu_pkg::AXIS_Y) - unit_comp(old_r, spu_pkg::AXIS_Y);
  assign dm_z    = unit_comp(e_prop, spu_pkg::AXIS_Z) - unit_comp(old_r, spu_pkg::AXIS_Z);

  assign mem_we = (st == B_CLEAR) || ((st == B_DECIDE) && move_ok);
  assign mem_wa = (st == B_CLEAR) ? clr_addr : e_site;
  assign mem_wd = (st == B_CLEAR) ? spu_pkg::SPIN_PX : e_prop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[mem_wa] <= mem_wd;
    end
    mem_q <= lattice[mem_ra];
  end

  // one field term per cycle through the shared multiplier
  always_comb begin
    case (cnt)
      3'd0: begin
        f_sel = fields.x;
        m_sel = mag_x;
      end
      3'd1: begin
        f_sel = fields.y;
        m_sel = mag_y;
      end
      default: begin
        f_sel = fields.z;
        m_sel = mag_z;
      end
    endcase
  end
  assign mul_full = f_sel * m_sel;

  assign clr_busy = (st == B_CLEAR);
  assign q_pop    = (st == B_IDLE) && !q_empty;
  assign load_out = (st == B_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      bond      <= BOND_RESET;
      mag_x     <= MAG_RESET;
      mag_y     <= '0;
      mag_z     <= '0;
    end else begin
      rd_valid <= (st == B_READ) && (cnt != 3'd7);
      rd_idx   <= cnt;
      if (rd_valid) begin
        if (rd_idx == 3'd0) begin
          old_r <= mem_q;
        end else begin
          b_old <= b_old + 4'(bond_term(old_r, mem_q));
          b_new <= b_new + 4'(bond_term(e_prop, mem_q));
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (st)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SITE) begin
            st <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            ent_r    <= q_entry;
            b_old    <= '0;
            b_new    <= '0;
            acc_flag <= 1'b0;
            cnt      <= '0;
            st       <= q_entry[EW-1] ? B_READ : B_MULT;
          end
        end
        B_READ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) begin
            st <= B_DECIDE;
          end
        end
        B_DECIDE: begin
          acc_flag <= move_ok;
          if (move_ok) begin
            bond  <= bond + BW'(db);
            mag_x <= mag_x + MW'(dm_x);
            mag_y <= mag_y + MW'(dm_y);
            mag_z <= mag_z + MW'(dm_z);
          end
          cnt <= '0;
          st  <= B_MULT;
        end
        B_MULT: begin
          prod_r <= TW'(mul_full);
          if (cnt == 3'd0) begin
            tot <= TW'(bond) << 8;
          end else begin
            tot <= tot - prod_r;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 3'd2) begin
            st <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (load_out) begin
            accepted     <= acc_flag && e_ok;
            bond_energy  <= spu_pkg::BOND_OUT_W'(bond);
            mag_x_out    <= spu_pkg::MAG_OUT_W'(mag_x);
            mag_y_out    <= spu_pkg::MAG_OUT_W'(mag_y);
            mag_z_out    <= spu_pkg::MAG_OUT_W'(mag_z);
            total_energy <= tot - prod_r;
            st           <= B_IDLE;
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/spu_check.sv
// port-level checks for the potts site update core, bound to the top level
module spu_check #(
  parameter int SIDE = spu_pkg::SIDE_DEFAULT
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic [spu_pkg::SITE_W-1:0]            site,
  input logic [spu_pkg::SPIN_W-1:0]            proposed_spin,
  input logic [spu_pkg::THR_W-1:0]             threshold,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  accepted,
  input logic signed [spu_pkg::BOND_OUT_W-1:0] bond_energy,
  input logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_x_out,
  input logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_y_out,
  input logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_z_out,
  input logic signed [spu_pkg::TOTAL_W-1:0]    total_energy,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [spu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input logic [spu_pkg::FIELD_W-1:0]           cfg_data
);

  localparam int   NSITES     = SIDE * SIDE * SIDE;
  localparam logic SITES_ODD  = NSITES % 2 == 1;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(bond_energy)
                               && $stable(total_energy))
    else $error("result changed while stalled");

  // front end works on one request at a time
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while front end busy");

  // every spin adds plus or minus one to exactly one axis
  a_mag_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mag_x_out[0] ^ mag_y_out[0] ^ mag_z_out[0]) == SITES_ODD))
    else $error("magnetisation parity broken");

  // clearing pass holds off requests and no result is pending after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind metropolis_potts_site_update_core spu_check #(.SIDE(SIDE)) u_check (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the potts site update core: directed moves, then random phases
module testbench;

  localparam int LAT_SIDE = spu_pkg::SIDE_DEFAULT;
  localparam int LAT_SITES = LAT_SIDE * LAT_SIDE * LAT_SIDE;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_MOVES = 305;
  localparam int NUM_PHASES = 6;
  localparam logic [spu_pkg::THR_W-1:0] THR_MAX = '1;
  localparam logic [spu_pkg::SPIN_W-1:0] SPIN_UNUSED_A = 3'd6;
  localparam logic [spu_pkg::SPIN_W-1:0] SPIN_UNUSED_B = 3'd7;

  typedef struct packed {
    logic                           acc;
    logic [spu_pkg::BOND_OUT_W-1:0] bond;
    logic [spu_pkg::MAG_OUT_W-1:0]  mx;
    logic [spu_pkg::MAG_OUT_W-1:0]  my;
    logic [spu_pkg::MAG_OUT_W-1:0]  mz;
    logic [spu_pkg::TOTAL_W-1:0]    total;
  } outcome_t;

  typedef struct packed {
    logic [spu_pkg::SITE_W-1:0] site;
    logic [spu_pkg::SPIN_W-1:0] spin;
    logic [spu_pkg::THR_W-1:0]  thr;
    logic                       fixed;
    logic                       acc;
  } move_row_t;

  // fixed rows come first, while the lattice still holds its reset state
  move_row_t directed_moves [21] = '{
    '{12'd0,    SPIN_UNUSED_A,    THR_MAX,      1'b1, 1'b0},
    '{12'd4095, SPIN_UNUSED_B,    THR_MAX,      1'b1, 1'b0},
    '{12'd0,    spu_pkg::SPIN_PX, 18'd0,        1'b1, 1'b0},
    '{12'd2730, spu_pkg::SPIN_PX, 18'd1,        1'b1, 1'b1},
    '{12'd4095, spu_pkg::SPIN_PX, THR_MAX,      1'b1, 1'b1},
    '{12'd0,    spu_pkg::SPIN_NX, THR_MAX,      1'b0, 1'b0},
    '{12'd0,    spu_pkg::SPIN_NX, 18'd0,        1'b0, 1'b0},
    '{12'd1,    spu_pkg::SPIN_PY, THR_MAX,      1'b0, 1'b0},
    '{12'd15,   spu_pkg::SPIN_NY, THR_MAX,      1'b0, 1'b0},
    '{12'd240,  spu_pkg::SPIN_PZ, THR_MAX,      1'b0, 1'b0},
    '{12'd3840, spu_pkg::SPIN_NZ, THR_MAX,      1'b0, 1'b0},
    '{12'd4095, spu_pkg::SPIN_NX, 18'd3071,     1'b0, 1'b0},
    '{12'd256,  spu_pkg::SPIN_NX, 18'd3073,     1'b0, 1'b0},
    '{12'd16,   spu_pkg::SPIN_NZ, 18'd0,        1'b0, 1'b0},
    '{12'd0,    spu_pkg::SPIN_PX, THR_MAX,      1'b0, 1'b0},
    '{12'd2048, spu_pkg::SPIN_PY, 18'd262142,   1'b0, 1'b0},
    '{12'd1365, spu_pkg::SPIN_NY, 18'd131072,   1'b0, 1'b0},
    '{12'd0,    SPIN_UNUSED_B,    18'd0,        1'b0, 1'b0},
    '{12'd4095, SPIN_UNUSED_A,    18'd0,        1'b0, 1'b0},
    '{12'd17,   spu_pkg::SPIN_PZ, 18'd512,      1'b0, 1'b0},
    '{12'd273,  spu_pkg::SPIN_NZ, 18'd2560,     1'b0, 1'b0}
  };

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [spu_pkg::SITE_W-1:0]            site = '0;
  logic [spu_pkg::SPIN_W-1:0]            proposed_spin = '0;
  logic [spu_pkg::THR_W-1:0]             threshold = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic                                  accepted;
  logic signed [spu_pkg::BOND_OUT_W-1:0] bond_energy;
  logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_x_out;
  logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_y_out;
  logic signed [spu_pkg::MAG_OUT_W-1:0]  mag_z_out;
  logic signed [spu_pkg::TOTAL_W-1:0]    total_energy;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [spu_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
  logic [spu_pkg::FIELD_W-1:0]           cfg_data = '0;

  metropolis_potts_site_update_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .site          (site),
    .proposed_spin (proposed_spin),
    .threshold     (threshold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .bond_energy   (bond_energy),
    .mag_x_out     (mag_x_out),
    .mag_y_out     (mag_y_out),
    .mag_z_out     (mag_z_out),
    .total_energy  (total_energy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the lattice, running totals and field registers
  logic [spu_pkg::SPIN_W-1:0] lattice [LAT_SITES];
  longint                     bond_now;
  longint                     mag_now [3];
  longint                     field_cur [3];
  outcome_t                   pending_results [$];
  int                         errors = 0;
  int                         quiet_cycles = 0;
  int                         stall_left = 0;
  bit                         calm = 1'b0;

  function automatic int wrap_site(input int x, input int y, input int z);
    return ((x + LAT_SIDE) % LAT_SIDE) * LAT_SIDE * LAT_SIDE
           + ((y + LAT_SIDE) % LAT_SIDE) * LAT_SIDE + (z + LAT_SIDE) % LAT_SIDE;
  endfunction

  function automatic int pair_bond(input logic [spu_pkg::SPIN_W-1:0] a,
                                   input logic [spu_pkg::SPIN_W-1:0] b);
    if (a == b) return -1;
    if (a[2:1] == b[2:1]) return 1;
    return 0;
  endfunction

  // change in neighbour bond count if site s flips to spin p
  function automatic int bond_delta(input int s, input logic [spu_pkg::SPIN_W-1:0] p);
    int x, y, z, d, k;
    int nbr [6];
    x = s / (LAT_SIDE * LAT_SIDE);
    y = (s / LAT_SIDE) % LAT_SIDE;
    z = s % LAT_SIDE;
    nbr[0] = wrap_site(x + 1, y, z);
    nbr[1] = wrap_site(x - 1, y, z);
    nbr[2] = wrap_site(x, y + 1, z);
    nbr[3] = wrap_site(x, y - 1, z);
    nbr[4] = wrap_site(x, y, z + 1);
    nbr[5] = wrap_site(x, y, z - 1);
    d = 0;
    for (k = 0; k < 6; k++)
      d += pair_bond(p, lattice[nbr[k]]) - pair_bond(lattice[s], lattice[nbr[k]]);
    return d;
  endfunction

  function automatic longint field_along(input logic [spu_pkg::SPIN_W-1:0] s);
    int ax;
    ax = int'(s[2:1]);
    return s[0] ? -field_cur[ax] : field_cur[ax];
  endfunction

  function automatic longint energy_change(input int s, input logic [spu_pkg::SPIN_W-1:0] p);
    return longint'(bond_delta(s, p)) * 256 - field_along(p) + field_along(lattice[s]);
  endfunction

  function automatic outcome_t pack_outcome(input logic acc, input longint b, input longint mx,
                                            input longint my, input longint mz,
                                            input longint tot);
    outcome_t o;
    o.acc = acc;
    o.bond = b[spu_pkg::BOND_OUT_W-1:0];
    o.mx = mx[spu_pkg::MAG_OUT_W-1:0];
    o.my = my[spu_pkg::MAG_OUT_W-1:0];
    o.mz = mz[spu_pkg::MAG_OUT_W-1:0];
    o.total = tot[spu_pkg::TOTAL_W-1:0];
    return o;
  endfunction

  // applies one move to the shadow lattice and returns the totals it reports
  function automatic outcome_t apply_move(input int s, input logic [spu_pkg::SPIN_W-1:0] p,
                                          input logic [spu_pkg::THR_W-1:0] t);
    logic                       acc;
    logic [spu_pkg::SPIN_W-1:0] old;
    int                         bd;
    longint                     tot;
    acc = 1'b0;
    if (p <= spu_pkg::SPIN_NZ && s < LAT_SITES) begin
      if (energy_change(s, p) < longint'(t)) begin
        acc = 1'b1;
        old = lattice[s];
        bd = bond_delta(s, p);
        mag_now[old[2:1]] -= (old[0] ? -1 : 1);
        mag_now[p[2:1]] += (p[0] ? -1 : 1);
        bond_now += bd;
        lattice[s] = p;
      end
    end
    tot = bond_now * 256 - field_cur[0] * mag_now[0] - field_cur[1] * mag_now[1]
          - field_cur[2] * mag_now[2];
    return pack_outcome(acc, bond_now, mag_now[0], mag_now[1], mag_now[2], tot);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_move(input logic [spu_pkg::SITE_W-1:0] s,
                           input logic [spu_pkg::SPIN_W-1:0] p,
                           input logic [spu_pkg::THR_W-1:0] t, input logic fixed,
                           input logic fixed_acc);
    outcome_t o;
    int       gap;
    in_valid <= 1'b1;
    site <= s;
    proposed_spin <= p;
    threshold <= t;
    do @(posedge clk); while (in_stall);
    o = apply_move(int'(s), p, t);
    if (fixed)
      o = pack_outcome(fixed_acc, longint'(-12288), longint'(4096), 64'sd0, 64'sd0,
                       longint'(-3145728));
    pending_results = {pending_results, o};
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_move();
    logic [spu_pkg::SITE_W-1:0] s;
    logic [spu_pkg::SPIN_W-1:0] p;
    logic [spu_pkg::THR_W-1:0]  t;
    longint                     c;
    int                         r, k;
    // half the moves land in a small block around the wrap corner
    if ($urandom_range(0, 1) == 0)
      s = spu_pkg::SITE_W'($urandom_range(0, LAT_SITES - 1));
    else
      s = spu_pkg::SITE_W'(wrap_site(LAT_SIDE - 2 + $urandom_range(0, 3),
                                     LAT_SIDE - 2 + $urandom_range(0, 3),
                                     LAT_SIDE - 2 + $urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 5)
      p = spu_pkg::SPIN_W'($urandom_range(SPIN_UNUSED_A, SPIN_UNUSED_B));
    else
      p = spu_pkg::SPIN_W'($urandom_range(spu_pkg::SPIN_PX, spu_pkg::SPIN_NZ));
    if (p <= spu_pkg::SPIN_NZ && s < LAT_SITES)
      c = energy_change(int'(s), p);
    else
      c = longint'($urandom_range(0, 4096));
    r = $urandom_range(0, 19);
    if (r == 0) begin
      t = '0;
    end else if (r < 6) begin
      t = spu_pkg::THR_W'($urandom());
    end else if (r < 11) begin
      t = spu_pkg::THR_W'($urandom_range(0, 4095));
    end else begin
      // just below, on and just above the energy change
      k = $urandom_range(0, 2);
      c = c + k - 1;
      t = (c < 0) ? '0 : c[spu_pkg::THR_W-1:0];
    end
    send_move(s, p, t, 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic load_fields(input logic [spu_pkg::FIELD_W-1:0] fx,
                             input logic [spu_pkg::FIELD_W-1:0] fy,
                             input logic [spu_pkg::FIELD_W-1:0] fz);
    logic [spu_pkg::FIELD_W-1:0]   vals [3];
    logic [spu_pkg::CFG_IDX_W-1:0] regs [3];
    int                            i;
    vals = '{fx, fy, fz};
    regs = '{spu_pkg::REG_FIELD_X, spu_pkg::REG_FIELD_Y, spu_pkg::REG_FIELD_Z};
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      field_cur[i] = longint'($signed(vals[i]));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // result checking and random output stall
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", longint'(want.acc), longint'(accepted));
        check_field("bond_energy", longint'($signed(want.bond)), longint'(bond_energy));
        check_field("mag_x_out", longint'($signed(want.mx)), longint'(mag_x_out));
        check_field("mag_y_out", longint'($signed(want.my)), longint'(mag_y_out));
        check_field("mag_z_out", longint'($signed(want.mz)), longint'(mag_z_out));
        check_field("total_energy", longint'($signed(want.total)), longint'(total_energy));
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
      stall_left <= calm ? 0 : $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i, ph, n;
    foreach (lattice[j]) lattice[j] = spu_pkg::SPIN_PX;
    bond_now = longint'(-3 * LAT_SITES);
    mag_now = '{LAT_SITES, 0, 0};
    field_cur = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(directed_moves); i++)
      send_move(directed_moves[i].site, directed_moves[i].spin, directed_moves[i].thr,
                directed_moves[i].fixed, directed_moves[i].acc);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      calm = (ph == 3);
      case (ph)
        0: begin
          load_fields(16'h0000, 16'h0000, 16'h0000);
        end
        1: begin
          load_fields(16'h7FFF, 16'h8000, 16'h0000);
        end
        2: begin
          load_fields(16'h8000, 16'h7FFF, 16'h8000);
        end
        3: begin
          load_fields(spu_pkg::FIELD_W'($urandom()), spu_pkg::FIELD_W'($urandom()),
                      spu_pkg::FIELD_W'($urandom()));
        end
        4: begin
          load_fields(spu_pkg::FIELD_W'($urandom_range(0, 2047) - 1024),
                      spu_pkg::FIELD_W'($urandom_range(0, 2047) - 1024),
                      spu_pkg::FIELD_W'($urandom_range(0, 2047) - 1024));
        end
        default: begin
          load_fields(16'h0100, 16'hFE00, 16'h7FFF);
        end
      endcase
      for (n = 0; n < PHASE_MOVES; n++) begin
        // now and then let every outstanding request drain first
        if ($urandom_range(0, 199) == 0) wait_idle();
        send_random_move();
      end
    end

    wait_idle();
    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> metropolis_potts_site_update_core.f
rtl/spu_pkg.sv
rtl/spu_front.sv
rtl/spu_fifo.sv
rtl/spu_back.sv
rtl/metropolis_potts_site_update_core.sv
rtl/spu_check.sv
tb/sv/testbench.sv
